// ----- rtl/core/fdrrf_pkg.sv -----
package fdrrf_pkg;

   localparam int SCREEN_HEIGHT = 342;
   localparam int SCREEN_WIDTH  = 512;
   localparam int ROW_WORDS     = SCREEN_WIDTH / 32;
   localparam int FRAME_WORDS   = SCREEN_HEIGHT * ROW_WORDS;

   localparam int ADDR_W  = $clog2(FRAME_WORDS);
   localparam int CNT_W   = $clog2(FRAME_WORDS + 1);
   localparam int ROW_W   = $clog2(SCREEN_HEIGHT + 1);
   localparam int COL_W   = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
   localparam int WORD_W  = 32;
   localparam int INDEX_W = 13;
   localparam int PAGE_W  = 8;
   localparam int ADJ_W   = 8;
   localparam int OROW_W  = 9;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_PAGE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [PAGE_W-1:0] PAGE_MAIN = PAGE_W'(1);

   localparam logic [ADJ_W-1:0] ADJ_FULL_MAX = ADJ_W'(2);
   localparam logic [ADJ_W-1:0] ADJ_HALF_MAX = ADJ_W'(4);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FWD,
      ST_LIMIT,
      ST_BINIT,
      ST_BWD,
      ST_CINIT,
      ST_COPY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              main_en;
      logic              alt_en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } frame_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } shadow_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] main_q;
      logic [WORD_W-1:0] alt_q;
      logic [WORD_W-1:0] shadow_q;
   } rd_data_type;

   function automatic logic [CNT_W-1:0] row_base(input logic [ROW_W-1:0] row);
      return CNT_W'(row) * CNT_W'(ROW_WORDS);
   endfunction

endpackage

// ----- rtl/core/frame_dirty_row_range_finder.sv -----
// Finds a range of rows of the shown frame that differ from the shadow copy,
// within a row window set by the time adjust, and copies them across. A word
// write or page select does not make the block busy. A tick that finds a
// difference scans forward to the first differing word, then back from the
// end of the row window to the last differing word, then copies the rows
// between them, 16 words per row, and then strobes. A tick that finds
// nothing scans forward to the end of the frame and goes idle. Every scan
// and copy step goes through the single read port of the frame stores, one
// word a cycle. After reset the block clears all three stores, one word a
// cycle, and holds busy until all 5472 words are cleared. Results come out
// on a one-cycle strobe and cannot be held off; a tick that finds no change
// gives no strobe.
module frame_dirty_row_range_finder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic                          req_buffer_select,
   input  logic [fdrrf_pkg::INDEX_W-1:0] req_word_index,
   input  logic [fdrrf_pkg::WORD_W-1:0]  req_word_data,
   input  logic [fdrrf_pkg::PAGE_W-1:0]  req_page_value,
   input  logic [fdrrf_pkg::ADJ_W-1:0]   req_time_adjust,
   output logic                          rsp_strobe,
   output logic                          rsp_changed,
   output logic [fdrrf_pkg::OROW_W-1:0]  rsp_first_row,
   output logic [fdrrf_pkg::OROW_W-1:0]  rsp_end_row
);

   fdrrf_pkg::frame_wr_type  frame_wr;
   fdrrf_pkg::shadow_wr_type shadow_wr;
   fdrrf_pkg::rd_req_type    rd_req;
   fdrrf_pkg::rd_data_type   rd_data;

   fdrrf_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_buffer_select (req_buffer_select),
      .req_word_index    (req_word_index),
      .req_word_data     (req_word_data),
      .req_page_value    (req_page_value),
      .req_time_adjust   (req_time_adjust),
      .rsp_strobe        (rsp_strobe),
      .rsp_changed       (rsp_changed),
      .rsp_first_row     (rsp_first_row),
      .rsp_end_row       (rsp_end_row),
      .frame_wr          (frame_wr),
      .shadow_wr         (shadow_wr),
      .rd_req            (rd_req),
      .rd_data           (rd_data)
   );

   fdrrf_store u_store (
      .clock     (clock),
      .frame_wr  (frame_wr),
      .shadow_wr (shadow_wr),
      .rd_req    (rd_req),
      .rd_data   (rd_data)
   );

endmodule

// ----- rtl/core/fdrrf_store.sv -----
module fdrrf_store (
   input  logic                     clock,
   input  fdrrf_pkg::frame_wr_type  frame_wr,
   input  fdrrf_pkg::shadow_wr_type shadow_wr,
   input  fdrrf_pkg::rd_req_type    rd_req,
   output fdrrf_pkg::rd_data_type   rd_data
);

   logic [fdrrf_pkg::WORD_W-1:0] main_mem   [fdrrf_pkg::FRAME_WORDS];
   logic [fdrrf_pkg::WORD_W-1:0] alt_mem    [fdrrf_pkg::FRAME_WORDS];
   logic [fdrrf_pkg::WORD_W-1:0] shadow_mem [fdrrf_pkg::FRAME_WORDS];

   logic [fdrrf_pkg::WORD_W-1:0] main_q_ff;
   logic [fdrrf_pkg::WORD_W-1:0] alt_q_ff;
   logic [fdrrf_pkg::WORD_W-1:0] shadow_q_ff;

   always_ff @(posedge clock) begin
      if (frame_wr.main_en) begin
         main_mem[frame_wr.addr] <= frame_wr.data;
      end
      if (frame_wr.alt_en) begin
         alt_mem[frame_wr.addr] <= frame_wr.data;
      end
      if (shadow_wr.en) begin
         shadow_mem[shadow_wr.addr] <= shadow_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         main_q_ff   <= main_mem[rd_req.addr];
         alt_q_ff    <= alt_mem[rd_req.addr];
         shadow_q_ff <= shadow_mem[rd_req.addr];
      end
   end

   assign rd_data.main_q   = main_q_ff;
   assign rd_data.alt_q    = alt_q_ff;
   assign rd_data.shadow_q = shadow_q_ff;

endmodule

// ----- rtl/core/fdrrf_ctrl.sv -----
module fdrrf_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_command,
   input  logic                                req_buffer_select,
   input  logic [fdrrf_pkg::INDEX_W-1:0]       req_word_index,
   input  logic [fdrrf_pkg::WORD_W-1:0]        req_word_data,
   input  logic [fdrrf_pkg::PAGE_W-1:0]        req_page_value,
   input  logic [fdrrf_pkg::ADJ_W-1:0]         req_time_adjust,
   output logic                                rsp_strobe,
   output logic                                rsp_changed,
   output logic [fdrrf_pkg::OROW_W-1:0]        rsp_first_row,
   output logic [fdrrf_pkg::OROW_W-1:0]        rsp_end_row,
   output fdrrf_pkg::frame_wr_type             frame_wr,
   output fdrrf_pkg::shadow_wr_type            shadow_wr,
   output fdrrf_pkg::rd_req_type               rd_req,
   input  fdrrf_pkg::rd_data_type              rd_data
);

   fdrrf_pkg::state_type state_ff, state_in;

   logic [fdrrf_pkg::CNT_W-1:0]  addr_ff, addr_in;
   logic [fdrrf_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [fdrrf_pkg::COL_W-1:0]  col_ff, col_in;
   logic                         pend_ff, pend_in;
   logic [fdrrf_pkg::ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [fdrrf_pkg::ROW_W-1:0]  pend_row_ff, pend_row_in;
   logic [fdrrf_pkg::ROW_W-1:0]  first_row_ff, first_row_in;
   logic [fdrrf_pkg::ROW_W-1:0]  end_row_ff, end_row_in;
   logic [fdrrf_pkg::ROW_W-1:0]  limit_ff, limit_in;
   logic [fdrrf_pkg::ROW_W-1:0]  max_rows_ff, max_rows_in;
   logic [fdrrf_pkg::ROW_W-1:0]  resume_ff, resume_in;
   logic [fdrrf_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [fdrrf_pkg::CNT_W-1:0]  copy_end_ff, copy_end_in;

   logic                         accept;
   logic [fdrrf_pkg::WORD_W-1:0] shown_q;
   logic                         diff;
   logic                         fwd_issue;
   logic                         copy_issue;
   logic                         clear_last;
   logic                         resume_ok;
   logic [fdrrf_pkg::ROW_W:0]    window_sum;

   assign accept     = start && (state_ff == fdrrf_pkg::ST_IDLE);
   assign shown_q    = (page_ff == fdrrf_pkg::PAGE_MAIN) ? rd_data.main_q : rd_data.alt_q;
   assign diff       = pend_ff && (shown_q != rd_data.shadow_q);
   assign fwd_issue  = addr_ff < fdrrf_pkg::CNT_W'(fdrrf_pkg::FRAME_WORDS);
   assign copy_issue = addr_ff < copy_end_ff;
   assign clear_last = addr_ff == fdrrf_pkg::CNT_W'(fdrrf_pkg::FRAME_WORDS - 1);
   assign resume_ok  = resume_ff < fdrrf_pkg::ROW_W'(fdrrf_pkg::SCREEN_HEIGHT);
   assign window_sum = (fdrrf_pkg::ROW_W + 1)'(first_row_ff)
                     + (fdrrf_pkg::ROW_W + 1)'(max_rows_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fdrrf_pkg::ST_CLEAR: begin
            if (clear_last) begin
               state_in = fdrrf_pkg::ST_IDLE;
            end
         end
         fdrrf_pkg::ST_IDLE: begin
            if (accept && (req_command == fdrrf_pkg::CMD_TICK) && resume_ok) begin
               state_in = fdrrf_pkg::ST_FWD;
            end
         end
         fdrrf_pkg::ST_FWD: begin
            if (diff) begin
               state_in = fdrrf_pkg::ST_LIMIT;
            end else if (!fwd_issue && !pend_ff) begin
               state_in = fdrrf_pkg::ST_IDLE;
            end
         end
         fdrrf_pkg::ST_LIMIT: state_in = fdrrf_pkg::ST_BINIT;
         fdrrf_pkg::ST_BINIT: state_in = fdrrf_pkg::ST_BWD;
         fdrrf_pkg::ST_BWD: begin
            if (diff) begin
               state_in = fdrrf_pkg::ST_CINIT;
            end
         end
         fdrrf_pkg::ST_CINIT: state_in = fdrrf_pkg::ST_COPY;
         fdrrf_pkg::ST_COPY: begin
            if (!copy_issue && !pend_ff) begin
               state_in = fdrrf_pkg::ST_DONE;
            end
         end
         fdrrf_pkg::ST_DONE: state_in = fdrrf_pkg::ST_IDLE;
         default: state_in = fdrrf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      addr_in      = addr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pend_in      = 1'b0;
      pend_addr_in = addr_ff[fdrrf_pkg::ADDR_W-1:0];
      pend_row_in  = row_ff;
      first_row_in = first_row_ff;
      end_row_in   = end_row_ff;
      limit_in     = limit_ff;
      max_rows_in  = max_rows_ff;
      resume_in    = resume_ff;
      page_in      = page_ff;
      copy_end_in  = copy_end_ff;

      frame_wr.main_en = 1'b0;
      frame_wr.alt_en  = 1'b0;
      frame_wr.addr    = req_word_index[fdrrf_pkg::ADDR_W-1:0];
      frame_wr.data    = req_word_data;
      shadow_wr.en     = 1'b0;
      shadow_wr.addr   = pend_addr_ff;
      shadow_wr.data   = shown_q;
      rd_req.en        = 1'b0;
      rd_req.addr      = addr_ff[fdrrf_pkg::ADDR_W-1:0];

      unique case (state_ff)
         fdrrf_pkg::ST_CLEAR: begin
            frame_wr.main_en = 1'b1;
            frame_wr.alt_en  = 1'b1;
            frame_wr.addr    = addr_ff[fdrrf_pkg::ADDR_W-1:0];
            frame_wr.data    = '0;
            shadow_wr.en     = 1'b1;
            shadow_wr.addr   = addr_ff[fdrrf_pkg::ADDR_W-1:0];
            shadow_wr.data   = '0;
            addr_in          = addr_ff + 1'b1;
         end
         fdrrf_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  fdrrf_pkg::CMD_WRITE: begin
                     if (fdrrf_pkg::CNT_W'(req_word_index) <
                         fdrrf_pkg::CNT_W'(fdrrf_pkg::FRAME_WORDS)) begin
                        frame_wr.main_en = !req_buffer_select;
                        frame_wr.alt_en  = req_buffer_select;
                     end
                  end
                  fdrrf_pkg::CMD_PAGE: page_in = req_page_value;
                  fdrrf_pkg::CMD_TICK: begin
                     if (req_time_adjust <= fdrrf_pkg::ADJ_FULL_MAX) begin
                        max_rows_in = fdrrf_pkg::ROW_W'(fdrrf_pkg::SCREEN_HEIGHT);
                     end else if (req_time_adjust <= fdrrf_pkg::ADJ_HALF_MAX) begin
                        max_rows_in = fdrrf_pkg::ROW_W'(fdrrf_pkg::SCREEN_HEIGHT / 2);
                     end else begin
                        max_rows_in = fdrrf_pkg::ROW_W'(fdrrf_pkg::SCREEN_HEIGHT / 4);
                     end
                     if (resume_ok) begin
                        addr_in = fdrrf_pkg::row_base(resume_ff);
                        row_in  = resume_ff;
                        col_in  = '0;
                     end else begin
                        resume_in = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         fdrrf_pkg::ST_FWD: begin
            if (diff) begin
               first_row_in = pend_row_ff;
            end else begin
               if (!fwd_issue && !pend_ff) begin
                  resume_in = '0;
               end
               if (fwd_issue) begin
                  rd_req.en = 1'b1;
                  pend_in   = 1'b1;
                  addr_in   = addr_ff + 1'b1;
                  if (col_ff == fdrrf_pkg::COL_W'(fdrrf_pkg::ROW_WORDS - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
         end
         fdrrf_pkg::ST_LIMIT: begin
            if (window_sum >= (fdrrf_pkg::ROW_W + 1)'(fdrrf_pkg::SCREEN_HEIGHT)) begin
               limit_in  = fdrrf_pkg::ROW_W'(fdrrf_pkg::SCREEN_HEIGHT);
               resume_in = '0;
            end else begin
               limit_in  = window_sum[fdrrf_pkg::ROW_W-1:0];
               resume_in = window_sum[fdrrf_pkg::ROW_W-1:0];
            end
         end
         fdrrf_pkg::ST_BINIT: begin
            addr_in = fdrrf_pkg::row_base(limit_ff) - 1'b1;
            row_in  = limit_ff - 1'b1;
            col_in  = fdrrf_pkg::COL_W'(fdrrf_pkg::ROW_WORDS - 1);
         end
         fdrrf_pkg::ST_BWD: begin
            if (diff) begin
               end_row_in = pend_row_ff + 1'b1;
            end else begin
               rd_req.en = 1'b1;
               pend_in   = 1'b1;
               if (addr_ff != '0) begin
                  addr_in = addr_ff - 1'b1;
                  if (col_ff == '0) begin
                     col_in = fdrrf_pkg::COL_W'(fdrrf_pkg::ROW_WORDS - 1);
                     row_in = row_ff - 1'b1;
                  end else begin
                     col_in = col_ff - 1'b1;
                  end
               end
            end
         end
         fdrrf_pkg::ST_CINIT: begin
            addr_in     = fdrrf_pkg::row_base(first_row_ff);
            copy_end_in = fdrrf_pkg::row_base(end_row_ff);
         end
         fdrrf_pkg::ST_COPY: begin
            shadow_wr.en = pend_ff;
            if (copy_issue) begin
               rd_req.en = 1'b1;
               pend_in   = 1'b1;
               addr_in   = addr_ff + 1'b1;
            end
         end
         fdrrf_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fdrrf_pkg::ST_CLEAR;
         addr_ff   <= '0;
         pend_ff   <= 1'b0;
         resume_ff <= '0;
         page_ff   <= fdrrf_pkg::PAGE_MAIN;
      end else begin
         state_ff  <= state_in;
         addr_ff   <= addr_in;
         pend_ff   <= pend_in;
         resume_ff <= resume_in;
         page_ff   <= page_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      pend_addr_ff <= pend_addr_in;
      pend_row_ff  <= pend_row_in;
      first_row_ff <= first_row_in;
      end_row_ff   <= end_row_in;
      limit_ff     <= limit_in;
      max_rows_ff  <= max_rows_in;
      copy_end_ff  <= copy_end_in;
   end

   assign busy          = state_ff != fdrrf_pkg::ST_IDLE;
   assign rsp_strobe    = state_ff == fdrrf_pkg::ST_DONE;
   assign rsp_changed   = rsp_strobe;
   assign rsp_first_row = fdrrf_pkg::OROW_W'(first_row_ff);
   assign rsp_end_row   = fdrrf_pkg::OROW_W'(end_row_ff);

endmodule
